/* src/tbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared constants for the tile background renderer: function codes,
// configuration register indexes and video memory address map.
// ----------------------------------------------------------------------------
package tbr_pkg;

  localparam int unsigned DATA_W = 8;

  localparam logic [1:0] FUNC_ADDR   = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_RENDER = 2'd2;

  localparam logic [1:0] CFG_NT_SELECT = 2'd0;
  localparam logic [1:0] CFG_PAT_HIGH  = 2'd1;
  localparam logic [1:0] CFG_STEP_32   = 2'd2;
  localparam logic [1:0] CFG_BG_ENABLE = 2'd3;

  localparam logic [1:0] PHASE_HIGH = 2'd0;
  localparam logic [1:0] PHASE_LOW  = 2'd1;
  localparam logic [1:0] PHASE_FULL = 2'd2;

  localparam logic [15:0] NT_BASE     = 16'h2000;
  localparam logic [15:0] ATTR_OFFSET = 16'h03C0;
  localparam logic [15:0] PAL_BASE    = 16'h3F00;
  localparam logic [15:0] PAT_HIGH    = 16'h1000;
  localparam logic [15:0] PLANE_HI    = 16'h0008;

  localparam logic [7:0] LAST_LINE = 8'd239;

endpackage

/* src/tbr_vram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbr_vram
// Video memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tbr_vram #(
  parameter int unsigned Depth = 16384
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(Depth)-1:0]       waddr_i,
  input  logic [tbr_pkg::DATA_W-1:0]     wdata_i,
  input  logic [$clog2(Depth)-1:0]       raddr_i,
  output logic [tbr_pkg::DATA_W-1:0]     rdata_o
);

  logic [tbr_pkg::DATA_W-1:0] mem [Depth];
  logic [tbr_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/tile_background_renderer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_renderer_top
// Address/data port access to a 16 KiB video memory and per-tile background
// rendering into eight pixel results.
// A render makes four dependent reads (attribute, tile index, both pattern
// planes) and eight palette reads through the single read port, putting out
// one pixel per cycle in the palette phase; busy_o stays high, so no new
// request is taken until the render is through. Reset: the memory is cleared
// one entry per cycle, with busy_o high until every entry is written;
// configuration transfers are taken throughout. No result stall.
// ----------------------------------------------------------------------------
module tile_background_renderer_top #(
  parameter int unsigned VRAM_DEPTH = 16384
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] func_i,
  input  logic [7:0] data_i,
  input  logic [7:0] scanline_i,
  input  logic [4:0] tile_col_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [1:0] cfg_data_i,
  output logic       pixel_valid_o,
  output logic [7:0] pixel_x_o,
  output logic [7:0] pixel_y_o,
  output logic [7:0] color_byte_o,
  output logic       opaque_o,
  output logic       last_o
);

  localparam int unsigned AW = $clog2(VRAM_DEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ATTR  = 3'd2;
  localparam logic [2:0] ST_TILE  = 3'd3;
  localparam logic [2:0] ST_LO    = 3'd4;
  localparam logic [2:0] ST_HI    = 3'd5;
  localparam logic [2:0] ST_PIX   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic [1:0]  nt_sel_q;
  logic        pat_high_q, step32_q, bg_en_q;

  logic [15:0] ptr_q, ptr_d;
  logic [1:0]  phase_q, phase_d;

  logic [7:0]  line_q, line_d;
  logic [4:0]  col_q, col_d;
  logic [1:0]  pal_q, pal_d;
  logic [15:0] pbase_q, pbase_d;
  logic [7:0]  lo_q, lo_d, hi_q, hi_d;
  logic [2:0]  k_q, k_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  px_q, px_d, py_q, py_d;
  logic        opaque_q, opaque_d, last_q, last_d;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic [15:0]   raddr_full;

  logic [4:0]  row;
  logic [2:0]  fine;
  logic [15:0] nt_base, attr_addr, tile_addr, pal_addr;
  logic [7:0]  attr_sh, hi_cur;
  logic [1:0]  bits;

  tbr_vram #(
    .Depth(VRAM_DEPTH)
  ) u_vram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  assign row       = line_q[7:3];
  assign fine      = line_q[2:0];
  assign nt_base   = tbr_pkg::NT_BASE + {4'b0, nt_sel_q, 10'b0};
  assign attr_addr = nt_base + tbr_pkg::ATTR_OFFSET + {10'b0, row[4:2], 3'b0}
                     + {13'b0, col_q[4:2]};
  assign tile_addr = nt_base + {6'b0, row, col_q};
  assign attr_sh   = mem_rdata >> {row[1], col_q[1], 1'b0};
  assign hi_cur    = (k_q == 3'd0) ? mem_rdata : hi_q;
  assign bits      = {hi_cur[3'd7 - k_q], lo_q[3'd7 - k_q]};
  assign pal_addr  = tbr_pkg::PAL_BASE + {12'b0, pal_q, bits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nt_sel_q   <= '0;
      pat_high_q <= 1'b0;
      step32_q   <= 1'b0;
      bg_en_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tbr_pkg::CFG_NT_SELECT: nt_sel_q   <= cfg_data_i;
        tbr_pkg::CFG_PAT_HIGH:  pat_high_q <= cfg_data_i[0];
        tbr_pkg::CFG_STEP_32:   step32_q   <= cfg_data_i[0];
        tbr_pkg::CFG_BG_ENABLE: bg_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    ptr_d       = ptr_q;
    phase_d     = phase_q;
    line_d      = line_q;
    col_d       = col_q;
    pal_d       = pal_q;
    pbase_d     = pbase_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    out_valid_d = 1'b0;
    px_d        = px_q;
    py_d        = py_q;
    opaque_d    = opaque_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q[AW-1:0];
    mem_wdata   = data_i;
    raddr_full  = attr_addr;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(VRAM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            tbr_pkg::FUNC_ADDR: begin
              if (phase_q == tbr_pkg::PHASE_HIGH || phase_q == tbr_pkg::PHASE_FULL) begin
                ptr_d   = {data_i, 8'h00};
                phase_d = tbr_pkg::PHASE_LOW;
              end else if (phase_q == tbr_pkg::PHASE_LOW) begin
                ptr_d   = ptr_q + {8'h00, data_i};
                phase_d = tbr_pkg::PHASE_FULL;
              end
            end
            tbr_pkg::FUNC_DATA: begin
              if (phase_q == tbr_pkg::PHASE_FULL) begin
                mem_we = 1'b1;
                ptr_d  = ptr_q + (step32_q ? 16'd32 : 16'd1);
              end
            end
            tbr_pkg::FUNC_RENDER: begin
              if (bg_en_q && scanline_i <= tbr_pkg::LAST_LINE) begin
                line_d  = scanline_i;
                col_d   = tile_col_i;
                k_d     = '0;
                state_d = ST_ATTR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ATTR: begin
        raddr_full = attr_addr;
        state_d    = ST_TILE;
      end
      ST_TILE: begin
        raddr_full = tile_addr;
        pal_d      = attr_sh[1:0];
        state_d    = ST_LO;
      end
      ST_LO: begin
        pbase_d    = (pat_high_q ? tbr_pkg::PAT_HIGH : 16'h0000)
                     + {4'b0, mem_rdata, 4'b0} + {13'b0, fine};
        raddr_full = pbase_d;
        state_d    = ST_HI;
      end
      ST_HI: begin
        raddr_full = pbase_q + tbr_pkg::PLANE_HI;
        lo_d       = mem_rdata;
        state_d    = ST_PIX;
      end
      ST_PIX: begin
        raddr_full  = pal_addr;
        hi_d        = hi_cur;
        out_valid_d = 1'b1;
        px_d        = {col_q, k_q};
        py_d        = line_q;
        opaque_d    = |bits;
        last_d      = (k_q == 3'd7);
        k_d         = k_q + 1'b1;
        if (k_q == 3'd7) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    mem_raddr = raddr_full[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      ptr_q       <= '0;
      phase_q     <= tbr_pkg::PHASE_HIGH;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      ptr_q       <= ptr_d;
      phase_q     <= phase_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q   <= line_d;
    col_q    <= col_d;
    pal_q    <= pal_d;
    pbase_q  <= pbase_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    px_q     <= px_d;
    py_q     <= py_d;
    opaque_q <= opaque_d;
    last_q   <= last_d;
  end

  assign pixel_valid_o = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign color_byte_o  = mem_rdata;
  assign opaque_o      = opaque_q;
  assign last_o        = last_q;

endmodule
